// ----- rtl/ecr_pkg.sv -----
// ---------------------------------------------------------------------------
// ecr_pkg
// Widths and constants shared by the outline rasterizer and its channels.
// ---------------------------------------------------------------------------
package ecr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 11;
  localparam int COLOR_BITS  = 32;

  localparam int PIX_BITS = COORD_BITS + 2;      // signed pixel coordinate
  localparam int WX_BITS  = COORD_BITS;          // walk x, never negative
  localparam int WY_BITS  = COORD_BITS + 1;      // walk y, signed
  localparam int SQ_BITS  = 2 * RADIUS_BITS;     // squared radius
  localparam int DEC_BITS = 48;                  // decision term, 4x scaled
  localparam int MUL_BITS = 2 * COORD_BITS + 3;  // signed multiplier operand

  // decision update constants
  localparam int CIRC_INIT    = 5;
  localparam int CIRC_DIAG    = 20;
  localparam int STEP_BIAS    = 12;
  localparam int R1_DIAG_BIAS = 8;
  localparam int R2_X_BIAS    = 8;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

endpackage

// ----- rtl/ecr_cmd_if.sv -----
// ---------------------------------------------------------------------------
// ecr_cmd_if
// Command channel: shape loads and step requests, valid/ready handshake.
// ---------------------------------------------------------------------------
interface ecr_cmd_if;
  import ecr_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [COORD_BITS-1:0]  center_x;
  logic [COORD_BITS-1:0]  center_y;
  logic [RADIUS_BITS-1:0] radius_x;
  logic [RADIUS_BITS-1:0] radius_y;
  logic [COLOR_BITS-1:0]  pixel_color;

  modport source (
    output valid, action, center_x, center_y, radius_x, radius_y, pixel_color,
    input  ready
  );

  modport sink (
    input  valid, action, center_x, center_y, radius_x, radius_y, pixel_color,
    output ready
  );

endinterface

// ----- rtl/ecr_pix_if.sv -----
// ---------------------------------------------------------------------------
// ecr_pix_if
// Pixel channel: one rasterized pixel per transfer, valid/ready handshake.
// ---------------------------------------------------------------------------
interface ecr_pix_if;
  import ecr_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [PIX_BITS-1:0] pixel_x;
  logic signed [PIX_BITS-1:0] pixel_y;
  logic [COLOR_BITS-1:0]      color_out;
  logic                       last_of_step;
  logic                       shape_done;

  modport source (
    output valid, pixel_x, pixel_y, color_out, last_of_step, shape_done,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, color_out, last_of_step, shape_done,
    output ready
  );

endinterface

// ----- rtl/ellipse_circle_rasterizer.sv -----
// ---------------------------------------------------------------------------
// ellipse_circle_rasterizer
// Midpoint circle / two-region ellipse outline rasterizer, one multiplier.
// ---------------------------------------------------------------------------
// Usage:
//   cmd : a load transfer (action 0) latches center, radii and color and
//         produces no pixel; a step transfer (action 1) advances one
//         iteration and produces 8 (circle) or 4 (ellipse) pixels on pix.
//         A step with no shape in progress produces nothing.
//   pix : one pixel per transfer; last_of_step marks the final pixel of a
//         step, shape_done the final pixel of the whole shape.
//   cmd.ready is high only while the sequencer is idle. A load runs LD1 to
//   LD4; a circle step runs EMIT and U1; a region-one ellipse step runs T1
//   to T3, EMIT and U1 to U3, and the step that enters region two adds I1
//   to I6 before EMIT; a region-two step runs EMIT and U1 to U3. These
//   states come from the single 27x27 multiplier shared by all decision
//   terms and from pixels leaving one at a time through the output register.
//   When pix stalls, the sequencer holds in its pixel state; the last pixel
//   of a step may still wait in the output register while the next command
//   is taken.
//   Reset (rst, synchronous) returns to idle with no shape and no pixel
//   pending.
// ---------------------------------------------------------------------------
module ellipse_circle_rasterizer (
  input logic      clk,
  input logic      rst,
  ecr_cmd_if.sink  cmd,
  ecr_pix_if.source pix
);
  import ecr_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_CIRCLE = 4'b0010,
    PH_R1     = 4'b0100,
    PH_R2     = 4'b1000
  } phase_t;

  typedef enum logic [17:0] {
    S_IDLE = 18'h00001,
    S_LD1  = 18'h00002,
    S_LD2  = 18'h00004,
    S_LD3  = 18'h00008,
    S_LD4  = 18'h00010,
    S_T1   = 18'h00020,
    S_T2   = 18'h00040,
    S_T3   = 18'h00080,
    S_I1   = 18'h00100,
    S_I2   = 18'h00200,
    S_I3   = 18'h00400,
    S_I4   = 18'h00800,
    S_I5   = 18'h01000,
    S_I6   = 18'h02000,
    S_EMIT = 18'h04000,
    S_U1   = 18'h08000,
    S_U2   = 18'h10000,
    S_U3   = 18'h20000
  } state_t;

  state_t state;
  phase_t phase;

  logic                      swapped;
  logic                      is_circle;
  logic [COORD_BITS-1:0]     cx;
  logic [COORD_BITS-1:0]     cy;
  logic [COLOR_BITS-1:0]     color;
  logic [RADIUS_BITS-1:0]    major;
  logic [RADIUS_BITS-1:0]    minor;
  logic [SQ_BITS-1:0]        major_sq;
  logic [SQ_BITS-1:0]        minor_sq;
  logic [WX_BITS-1:0]        walk_x;
  logic signed [WY_BITS-1:0] walk_y;
  logic [DEC_BITS-1:0]       decision;
  logic [DEC_BITS-1:0]       prod;
  logic [DEC_BITS-1:0]       acc;
  logic [2:0]                cnt;

  logic                      out_valid;
  logic signed [PIX_BITS-1:0] out_x;
  logic signed [PIX_BITS-1:0] out_y;
  logic [COLOR_BITS-1:0]     out_color;
  logic                      out_last;
  logic                      out_done;

  // shared multiplier
  logic signed [MUL_BITS-1:0]   mul_a;
  logic signed [MUL_BITS-1:0]   mul_b;
  logic signed [2*MUL_BITS-1:0] mul_full;

  logic cmd_fire;
  logic dec_neg;
  logic dec_zero;
  logic [2:0] last_idx;
  logic step_done;
  logic pix_load;
  logic [DEC_BITS-1:0] rhs;

  logic signed [PIX_BITS-1:0] xe, ye, u, v, dx, dy;
  logic signed [PIX_BITS-1:0] y_new_c, x_inc;
  logic swap_uv;

  logic signed [DEC_BITS-1:0] x8_dec, y8_dec;

  assign cmd_fire = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);

  assign dec_neg  = decision[DEC_BITS-1];
  assign dec_zero = (decision == '0);

  assign x8_dec = DEC_BITS'(walk_x) <<< 3;
  assign y8_dec = DEC_BITS'(walk_y) <<< 3;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_LD1: begin
        mul_a = MUL_BITS'(major);
        mul_b = MUL_BITS'(major);
      end
      S_LD2: begin
        mul_a = MUL_BITS'(minor);
        mul_b = MUL_BITS'(minor);
      end
      S_LD3: begin
        mul_a = MUL_BITS'(major_sq);
        mul_b = MUL_BITS'(minor);
      end
      S_T1: begin
        mul_a = MUL_BITS'(minor_sq);
        mul_b = MUL_BITS'(walk_x);
      end
      S_T2: begin
        mul_a = MUL_BITS'(major_sq);
        mul_b = MUL_BITS'(walk_y);
      end
      S_I1: begin
        // (2x + 1)^2
        mul_a = (MUL_BITS'(walk_x) <<< 1) + MUL_BITS'(1);
        mul_b = (MUL_BITS'(walk_x) <<< 1) + MUL_BITS'(1);
      end
      S_I2: begin
        mul_a = MUL_BITS'(prod[MUL_BITS-2:0]);
        mul_b = MUL_BITS'(minor_sq);
      end
      S_I3: begin
        // (y - 1)^2
        mul_a = MUL_BITS'(walk_y) - MUL_BITS'(1);
        mul_b = MUL_BITS'(walk_y) - MUL_BITS'(1);
      end
      S_I4: begin
        mul_a = MUL_BITS'(prod[MUL_BITS-2:0]);
        mul_b = MUL_BITS'(major_sq);
      end
      S_I5: begin
        mul_a = MUL_BITS'(major_sq);
        mul_b = MUL_BITS'(minor_sq);
      end
      S_U1: begin
        if (phase == PH_R1) begin
          mul_a = MUL_BITS'(minor_sq);
          mul_b = (MUL_BITS'(walk_x) <<< 3) + MUL_BITS'(STEP_BIAS);
        end else begin
          mul_a = MUL_BITS'(major_sq);
          mul_b = (MUL_BITS'(walk_y) <<< 3) - MUL_BITS'(STEP_BIAS);
        end
      end
      S_U2: begin
        if (phase == PH_R1) begin
          mul_a = MUL_BITS'(major_sq);
          mul_b = (MUL_BITS'(walk_y) <<< 3) - MUL_BITS'(R1_DIAG_BIAS);
        end else begin
          mul_a = MUL_BITS'(minor_sq);
          mul_b = (MUL_BITS'(walk_x) <<< 3) + MUL_BITS'(R2_X_BIAS);
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // region test: right-hand side is zero once y has reached zero
  assign rhs = (walk_y > 0) ? prod : '0;

  // pixel of the current iteration at index cnt
  always_comb begin
    xe      = PIX_BITS'(walk_x);
    ye      = PIX_BITS'(walk_y);
    swap_uv = (phase == PH_CIRCLE) ? cnt[2] : swapped;
    u       = swap_uv ? ye : xe;
    v       = swap_uv ? xe : ye;
    dx      = cnt[1] ? -u : u;
    dy      = (cnt[0] ^ cnt[1]) ? -v : v;
  end

  // end of shape, known before the update runs
  always_comb begin
    y_new_c = dec_neg ? ye : ye - PIX_BITS'(1);
    x_inc   = xe + PIX_BITS'(1);
    if (phase == PH_CIRCLE) begin
      step_done = (x_inc > y_new_c);
    end else if (phase == PH_R2) begin
      step_done = (walk_y <= 0);
    end else begin
      step_done = 1'b0;
    end
  end

  assign last_idx = (phase == PH_CIRCLE) ? 3'd7 : 3'd3;
  assign pix_load = (state == S_EMIT) && (!out_valid || pix.ready);

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_full[DEC_BITS-1:0];
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_IDLE;
      cnt   <= '0;
    end else begin
      if (state != S_EMIT) begin
        cnt <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            if (cmd.action == ACT_LOAD) begin
              cx        <= cmd.center_x;
              cy        <= cmd.center_y;
              color     <= cmd.pixel_color;
              swapped   <= (cmd.radius_y > cmd.radius_x);
              is_circle <= (cmd.radius_y == cmd.radius_x);
              major     <= (cmd.radius_y > cmd.radius_x) ? cmd.radius_y : cmd.radius_x;
              minor     <= (cmd.radius_y > cmd.radius_x) ? cmd.radius_x : cmd.radius_y;
              walk_x    <= '0;
              walk_y    <= WY_BITS'((cmd.radius_y > cmd.radius_x) ?
                                    cmd.radius_x : cmd.radius_y);
              phase     <= (cmd.radius_y == cmd.radius_x) ? PH_CIRCLE : PH_R1;
              state     <= S_LD1;
            end else if (phase == PH_R1) begin
              state <= S_T1;
            end else if (phase != PH_IDLE) begin
              state <= S_EMIT;
            end
          end
        end
        S_LD1: state <= S_LD2;
        S_LD2: begin
          major_sq <= prod[SQ_BITS-1:0];
          state    <= S_LD3;
        end
        S_LD3: begin
          minor_sq <= prod[SQ_BITS-1:0];
          state    <= S_LD4;
        end
        S_LD4: begin
          if (is_circle) begin
            decision <= DEC_BITS'(CIRC_INIT) - (DEC_BITS'(major) << 2);
          end else begin
            decision <= (DEC_BITS'(minor_sq) << 2) - (prod << 2) + DEC_BITS'(major_sq);
          end
          state <= S_IDLE;
        end
        S_T1: state <= S_T2;
        S_T2: begin
          acc   <= prod;
          state <= S_T3;
        end
        S_T3: begin
          state <= (acc < rhs) ? S_EMIT : S_I1;
        end
        S_I1: state <= S_I2;
        S_I2: state <= S_I3;
        S_I3: begin
          acc   <= prod;
          state <= S_I4;
        end
        S_I4: state <= S_I5;
        S_I5: begin
          acc   <= acc + (prod << 2);
          state <= S_I6;
        end
        S_I6: begin
          decision <= acc - (prod << 2);
          phase    <= PH_R2;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (pix_load) begin
            cnt <= cnt + 3'd1;
            if (cnt == last_idx) begin
              state <= S_U1;
            end
          end
        end
        S_U1: begin
          if (phase == PH_CIRCLE) begin
            if (dec_neg) begin
              decision <= decision + DEC_BITS'(x8_dec) + DEC_BITS'(STEP_BIAS);
            end else begin
              decision <= decision + DEC_BITS'(x8_dec) - DEC_BITS'(y8_dec)
                          + DEC_BITS'(CIRC_DIAG);
              walk_y   <= walk_y - WY_BITS'(1);
            end
            walk_x <= walk_x + WX_BITS'(1);
            if (step_done) begin
              phase <= PH_IDLE;
            end
            state <= S_IDLE;
          end else begin
            state <= S_U2;
          end
        end
        S_U2: begin
          if (phase == PH_R1) begin
            acc <= decision + prod;
          end else begin
            acc <= decision - prod;
          end
          state <= S_U3;
        end
        S_U3: begin
          if (phase == PH_R1) begin
            if (dec_neg) begin
              decision <= acc;
            end else begin
              decision <= acc - prod;
              walk_y   <= walk_y - WY_BITS'(1);
            end
            walk_x <= walk_x + WX_BITS'(1);
          end else begin
            if (!dec_neg && !dec_zero) begin
              decision <= acc;
            end else begin
              decision <= acc + prod;
              walk_x   <= walk_x + WX_BITS'(1);
            end
            walk_y <= walk_y - WY_BITS'(1);
            if (step_done) begin
              phase <= PH_IDLE;
            end
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pix_load) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_load) begin
      out_x     <= PIX_BITS'(cx) + dx;
      out_y     <= PIX_BITS'(cy) + dy;
      out_color <= color;
      out_last  <= (cnt == last_idx);
      out_done  <= (cnt == last_idx) && step_done;
    end
  end

  assign pix.valid        = out_valid;
  assign pix.pixel_x      = out_x;
  assign pix.pixel_y      = out_y;
  assign pix.color_out    = out_color;
  assign pix.last_of_step = out_last;
  assign pix.shape_done   = out_done;

  // checks
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    pix.valid && pix.shape_done |-> pix.last_of_step)
    else $error("shape_done without last_of_step");

  a_emit_index: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> cnt <= last_idx)
    else $error("pixel index past end of step");

  a_emit_phase: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> phase != PH_IDLE)
    else $error("pixels emitted with no shape");

  a_load_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready && cmd.action == ACT_LOAD |=> state == S_LD1)
    else $error("load transfer did not start setup");

endmodule
